// ----- sv/ght_pkg.sv -----
// Shared types and constants for the generational handle table.
`default_nettype none
package ght_pkg;

	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 8;
	localparam int ID_W     = 32;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_ACTIVATE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INVALIDATE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHECK      = 2'd2;

	localparam logic [STATUS_W-1:0] ST_VALID   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd3;

	typedef struct packed {
		logic capture;
		logic commit;
	} ght_cmd_t;

endpackage
`default_nettype wire

// ----- sv/generational_handle_table.sv -----
// Top level of the generational handle table.
//
// Requests arrive as transactions on the in channel (kind, handle_index,
// handle_id) and each produces exactly one result transaction on the out
// channel (status, new_id, new_index). Activate takes the lowest free slot
// and issues id_start plus the number of identifiers issued so far plus one.
// Invalidate and check compare the presented handle with the slot contents.
// A request is captured in idle, where its slot is read from the table; in
// evaluation it is resolved, the table written and result register loaded.
// No new request is taken while one is in evaluation: the table's single read
// port and the read-modify-write of one slot keep requests from overlapping.
// When the receiver stalls, the result waits in the output register and one
// further request may be taken; it then holds in evaluation until the
// register frees. Reset clears the occupancy bitmap at once, so every slot
// reads as free, and sets id_start to zero and the identifier counter to one.
// The configuration channel is always ready and writes id_start.
`default_nettype none
module generational_handle_table #(
	parameter int SLOTS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ght_pkg::ID_W-1:0]       cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ght_pkg::KIND_W-1:0]     kind,
	input  wire logic [ght_pkg::INDEX_W-1:0]    handle_index,
	input  wire logic [ght_pkg::ID_W-1:0]       handle_id,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [ght_pkg::STATUS_W-1:0]   status,
	output logic      [ght_pkg::ID_W-1:0]       new_id,
	output logic      [ght_pkg::INDEX_W-1:0]    new_index
);

	ght_pkg::ght_cmd_t cmd;

	assign cfg_ready = 1'b1;

	ght_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ght_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_valid),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.handle_index (handle_index),
		.handle_id    (handle_id),
		.status       (status),
		.new_id       (new_id),
		.new_index    (new_index)
	);

endmodule
`default_nettype wire

// ----- sv/ght_ctrl.sv -----
// Controller state machine that sequences each request through the datapath.
`default_nettype none
module ght_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ght_pkg::ght_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign slot_free   = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && (state_q == ST_IDLE);
	assign cmd.commit  = (state_q == ST_EVAL) && slot_free;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/ght_dp.sv -----
// Datapath with the slot table, occupancy bitmap, identifier counter and result register.
`default_nettype none
module ght_dp #(
	parameter int SLOTS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ght_pkg::ght_cmd_t              cmd,
	input  wire logic                           cfg_we,
	input  wire logic [ght_pkg::ID_W-1:0]       cfg_data,
	input  wire logic [ght_pkg::KIND_W-1:0]     kind,
	input  wire logic [ght_pkg::INDEX_W-1:0]    handle_index,
	input  wire logic [ght_pkg::ID_W-1:0]       handle_id,
	output logic      [ght_pkg::STATUS_W-1:0]   status,
	output logic      [ght_pkg::ID_W-1:0]       new_id,
	output logic      [ght_pkg::INDEX_W-1:0]    new_index
);

	localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [ght_pkg::INDEX_W:0] SLOTS_L = (ght_pkg::INDEX_W + 1)'(SLOTS);

	logic [ght_pkg::ID_W-1:0]     mem [SLOTS];
	logic [SLOTS-1:0]             used_q;
	logic [ght_pkg::ID_W-1:0]     id_start_q;
	logic [ght_pkg::ID_W-1:0]     cnt_q;
	logic [ght_pkg::KIND_W-1:0]   kind_q;
	logic [ght_pkg::INDEX_W-1:0]  idx_q;
	logic [ght_pkg::ID_W-1:0]     hid_q;
	logic [ght_pkg::ID_W-1:0]     rd_data_q;
	logic [ght_pkg::STATUS_W-1:0] status_q;
	logic [ght_pkg::ID_W-1:0]     new_id_q;
	logic [ght_pkg::INDEX_W-1:0]  new_index_q;

	logic [IDXW-1:0]              free_idx;
	logic                         found;
	logic [ght_pkg::ID_W-1:0]     nid;
	logic [ght_pkg::ID_W-1:0]     slot_val;
	logic                         in_range;
	logic                         match;
	logic [ght_pkg::STATUS_W-1:0] st_d;
	logic                         do_alloc;
	logic                         do_clear;

	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IDXW'(i);
			end
		end
	end

	assign found    = !(&used_q);
	assign nid      = id_start_q + cnt_q;
	assign in_range = {1'b0, idx_q} < SLOTS_L;
	assign slot_val = used_q[idx_q[IDXW-1:0]] ? rd_data_q : '0;
	assign match    = (slot_val == hid_q);

	always_comb begin
		do_alloc = 1'b0;
		do_clear = 1'b0;
		priority if (kind_q == ght_pkg::KIND_ACTIVATE) begin
			if (found) begin
				st_d     = ght_pkg::ST_VALID;
				do_alloc = 1'b1;
			end else begin
				st_d = ght_pkg::ST_NOSPACE;
			end
		end else if (!in_range) begin
			st_d = ght_pkg::ST_ERROR;
		end else if (kind_q == ght_pkg::KIND_INVALIDATE) begin
			st_d     = ght_pkg::ST_INVALID;
			do_clear = match;
		end else begin
			st_d = match ? ght_pkg::ST_VALID : ght_pkg::ST_INVALID;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= kind;
			idx_q     <= handle_index;
			hid_q     <= handle_id;
			rd_data_q <= mem[handle_index[IDXW-1:0]];
		end
		if (cmd.commit && do_alloc) begin
			mem[free_idx] <= nid;
		end
		if (cmd.commit) begin
			status_q    <= st_d;
			new_id_q    <= do_alloc ? nid : '0;
			new_index_q <= do_alloc ? ght_pkg::INDEX_W'(free_idx) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			id_start_q <= '0;
			cnt_q      <= ght_pkg::ID_W'(1);
		end else begin
			if (cfg_we) begin
				id_start_q <= cfg_data;
			end
			if (cmd.commit && do_alloc) begin
				used_q[free_idx] <= (nid != '0);
				cnt_q            <= cnt_q + ght_pkg::ID_W'(1);
			end
			if (cmd.commit && do_clear) begin
				used_q[idx_q[IDXW-1:0]] <= 1'b0;
			end
		end
	end

	assign status    = status_q;
	assign new_id    = new_id_q;
	assign new_index = new_index_q;

endmodule
`default_nettype wire

// ----- dv/ght_checker.sv -----
// Checker for the generational handle table: predicts each reply from the requests and compares.
module ght_checker #(
	parameter int SLOTS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	input  wire logic                         cfg_ready,
	input  wire logic [ght_pkg::ID_W-1:0]     cfg_data,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [ght_pkg::KIND_W-1:0]   kind,
	input  wire logic [ght_pkg::INDEX_W-1:0]  handle_index,
	input  wire logic [ght_pkg::ID_W-1:0]     handle_id,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [ght_pkg::STATUS_W-1:0] status,
	input  wire logic [ght_pkg::ID_W-1:0]     new_id,
	input  wire logic [ght_pkg::INDEX_W-1:0]  new_index,
	output int                                check_failures,
	output int                                replies_owed
);
	import ght_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     id;
		logic [INDEX_W-1:0]  index;
	} table_reply_t;

	logic [ID_W-1:0] slot_table [SLOTS];
	logic [ID_W-1:0] id_base;
	logic [ID_W-1:0] ids_issued;
	table_reply_t    owed_replies [$];
	table_reply_t    oldest;

	task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
			input logic [ID_W-1:0] want);
		check_failures++;
		if (check_failures < 100)
			$display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	function automatic table_reply_t resolve_request(input logic [KIND_W-1:0] req_kind,
			input logic [INDEX_W-1:0] idx, input logic [ID_W-1:0] hid);
		table_reply_t reply;
		int           free_slot;
		reply.status = ST_INVALID;
		reply.id = '0;
		reply.index = '0;
		free_slot = -1;
		if (req_kind == KIND_ACTIVATE) begin
			for (int s = SLOTS - 1; s >= 0; s--)
				if (slot_table[s] == '0)
					free_slot = s;
			if (free_slot < 0) begin
				reply.status = ST_NOSPACE;
			end else begin
				ids_issued = ids_issued + 1'b1;
				reply.id = id_base + ids_issued;
				slot_table[free_slot] = reply.id;
				reply.index = INDEX_W'(free_slot);
				reply.status = ST_VALID;
			end
		end else if (int'(idx) >= SLOTS) begin
			reply.status = ST_ERROR;
		end else if (slot_table[idx] != hid) begin
			reply.status = ST_INVALID;
		end else if (req_kind == KIND_INVALIDATE) begin
			slot_table[idx] = '0;
			reply.status = ST_INVALID;
		end else begin
			reply.status = ST_VALID;
		end
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_table[s])
				slot_table[s] = '0;
			id_base = '0;
			ids_issued = '0;
			owed_replies.delete();
			replies_owed = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_replies.size() == 0) begin
					report_mismatch("reply with no request outstanding, new_id", new_id, '0);
				end else begin
					oldest = owed_replies.pop_front();
					if (status != oldest.status)
						report_mismatch("status", ID_W'(status), ID_W'(oldest.status));
					if (new_id != oldest.id)
						report_mismatch("new_id", new_id, oldest.id);
					if (new_index != oldest.index)
						report_mismatch("new_index", ID_W'(new_index), ID_W'(oldest.index));
				end
			end
			if (cfg_valid && cfg_ready)
				id_base = cfg_data;
			if (in_valid && in_ready)
				owed_replies.push_back(resolve_request(kind, handle_index, handle_id));
			replies_owed = owed_replies.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Top of the handle table testbench: clock, reset, request traffic and the final verdict.
module testbench;
	import ght_pkg::*;

	localparam int TABLE_SLOTS = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 4;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [INDEX_W-1:0] index;
		logic [ID_W-1:0]    id;
	} handle_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [ID_W-1:0]     cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind = '0;
	logic [INDEX_W-1:0]  handle_index = '0;
	logic [ID_W-1:0]     handle_id = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     new_id;
	logic [INDEX_W-1:0]  new_index;

	int      check_failures;
	int      replies_owed;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      holds_wanted = 0;
	int      holds_served = 0;
	int      quiet_cycles = 0;
	handle_t live_handles [$];
	handle_t retired_handles [$];

	always #1 clk = ~clk;

	generational_handle_table #(
		.SLOTS(TABLE_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.handle_index(handle_index),
		.handle_id(handle_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.new_id(new_id),
		.new_index(new_index)
	);

	ght_checker #(
		.SLOTS(TABLE_SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.handle_index(handle_index),
		.handle_id(handle_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.new_id(new_id),
		.new_index(new_index),
		.check_failures(check_failures),
		.replies_owed(replies_owed)
	);

	// Handles granted by the table are collected so that later requests can present them.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready && status == ST_VALID && new_id != '0)
			live_handles.push_back('{index: new_index, id: new_id});
	end

	initial begin
		forever begin
			@(posedge clk);
			if (holds_wanted != holds_served) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_served = holds_wanted;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] idx,
			input logic [ID_W-1:0] hid);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		handle_index <= idx;
		handle_id <= hid;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_id_start(input logic [ID_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_noise();
		handle_t            h;
		logic [INDEX_W-1:0] idx;
		logic [ID_W-1:0]    hid;
		if (retired_handles.size() > 0 && $urandom_range(1)) begin
			h = retired_handles[$urandom_range(retired_handles.size() - 1)];
			send_request($urandom_range(1) ? KIND_INVALIDATE : KIND_CHECK, h.index, h.id);
		end else begin
			idx = $urandom_range(1) ? INDEX_W'($urandom_range(TABLE_SLOTS - 1))
					: INDEX_W'($urandom);
			hid = $urandom_range(3) == 0 ? '0 : ID_W'($urandom);
			send_request(KIND_W'($urandom_range(3)), idx, hid);
		end
	endtask

	task automatic run_phase(input int items, input int activate_pct);
		handle_t h;
		int      pick;
		int      roll;
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(99);
			if (roll < activate_pct) begin
				send_request(KIND_ACTIVATE, INDEX_W'($urandom), ID_W'($urandom));
			end else if (roll < 88 && live_handles.size() > 0) begin
				pick = $urandom_range(live_handles.size() - 1);
				h = live_handles[pick];
				if ($urandom_range(1)) begin
					send_request(KIND_CHECK, h.index, h.id);
				end else begin
					live_handles.delete(pick);
					retired_handles.push_back(h);
					send_request(KIND_INVALIDATE, h.index, h.id);
				end
			end else begin
				send_noise();
			end
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the base at all ones the first identifier wraps to zero and the slot stays free.
		write_id_start(32'hFFFF_FFFF);
		send_request(KIND_CHECK, 8'd0, 32'd0);
		send_request(KIND_CHECK, 8'hFF, 32'hFFFF_FFFF);
		send_request(KIND_INVALIDATE, INDEX_W'(TABLE_SLOTS), 32'd0);
		send_request(KIND_INVALIDATE, 8'd0, 32'd0);
		send_request(KIND_ACTIVATE, 8'hFF, 32'hFFFF_FFFF);
		send_request(KIND_ACTIVATE, 8'd0, 32'd0);
		send_request(KIND_ACTIVATE, 8'h55, 32'hA5A5_5A5A);
		send_request(KIND_CHECK, 8'd0, 32'd1);
		send_request(KIND_UNUSED, 8'd1, 32'd2);
		send_request(KIND_CHECK, 8'd1, 32'd3);
		send_request(KIND_INVALIDATE, 8'd0, 32'd2);
		send_request(KIND_INVALIDATE, 8'd0, 32'd1);
		send_request(KIND_CHECK, 8'd0, 32'd1);
		send_request(KIND_CHECK, 8'd0, 32'd0);
		send_request(KIND_ACTIVATE, 8'd0, 32'd0);
		send_request(KIND_CHECK, INDEX_W'(TABLE_SLOTS - 1), 32'd0);
		send_request(KIND_UNUSED, 8'h80, 32'h8000_0000);
		send_request(KIND_CHECK, INDEX_W'(TABLE_SLOTS - 1), 32'hFFFF_FFFF);
		drain();

		write_id_start(32'd0);
		run_phase(150, 60);

		send_idle_pct = 71;
		write_id_start(ID_W'($urandom));
		run_phase(150, 35);

		send_idle_pct = 0;
		recv_stall_pct = 71;
		write_id_start(32'h8000_0000);
		holds_wanted++;
		run_phase(150, 55);

		send_idle_pct = 36;
		recv_stall_pct = 36;
		write_id_start(32'hFFFF_FE00);
		run_phase(150, 45);

		if (check_failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
